### design/srtq_pkg.sv
// Shared types and codes for the sorted repeating timer queue.
`timescale 1ns / 1ps
`default_nettype none
package srtq_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_DEL  = 2'd1,
        KIND_FIRE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Decoded command as it travels from front to back
    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  timer_id;
        logic [31:0] period;    // zero already forced to one
        logic [31:0] delay;     // first delay, or period when zero
        logic [15:0] repeat_count;
        logic [15:0] event_tag;
    } item_t;

    // One result transaction
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot_id;
        logic [15:0] tag;
        status_t     status;
        logic        last;
    } res_t;

endpackage
`default_nettype wire

### design/srtq_front.sv
// Input stage: accepts stream transactions and decodes them into command items.
`timescale 1ns / 1ps
`default_nettype none
module srtq_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [103:0]   s_tdata,
    input  wire logic [1:0]     s_tuser,
    output logic                item_valid,
    input  wire logic           item_ready,
    output srtq_pkg::item_t     item
);
    import srtq_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic [31:0] per_fix;

    assign s_tready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Decode: zero period counts as one, zero first delay uses the period
    always_comb begin
        per_fix = (s_tdata[35:4] == 32'd0) ? 32'd1 : s_tdata[35:4];
        item_next.cmd          = cmd_t'(s_tuser);
        item_next.timer_id     = s_tdata[3:0];
        item_next.period       = per_fix;
        item_next.delay        = (s_tdata[67:36] != 32'd0) ? s_tdata[67:36] : per_fix;
        item_next.repeat_count = s_tdata[83:68];
        item_next.event_tag    = s_tdata[99:84];
        valid_next = valid_reg && !item_ready;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

### design/srtq_queue.sv
// Two-entry queue of decoded items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module srtq_queue (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  srtq_pkg::item_t in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output srtq_pkg::item_t out_item
);
    import srtq_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

### design/srtq_back.sv
// Command engine: timer table, slot scans, firing order and result register.
`timescale 1ns / 1ps
`default_nettype none
module srtq_back #(
    parameter int SLOTS     = srtq_pkg::SLOTS_DEF,
    parameter int TIME_BITS = srtq_pkg::TIME_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  srtq_pkg::item_t in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output srtq_pkg::res_t  out_res
);
    import srtq_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] expiry;
        logic [31:0]          period;
        logic [15:0]          remaining;
        logic [15:0]          tag;
        logic [15:0]          order;
    } rec_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ADD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // Timer table memory
    rec_t mem [SLOTS];
    rec_t rd_data;
    logic mem_we;
    logic [SW-1:0] mem_wa;
    rec_t mem_wd;

    state_t state_reg, state_next;
    item_t  item_reg, item_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [15:0] counter_reg, counter_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] due_reg, due_next;
    logic sel_reg, sel_next;              // 0 marks due slots, 1 selects earliest
    logic chk_v_reg, chk_v_next;
    logic [SW-1:0] chk_idx_reg, chk_idx_next;
    logic found_reg, found_next;
    logic [SW-1:0] best_reg, best_next;
    logic [TIME_BITS-1:0] bd_reg, bd_next;
    logic [15:0] ba_reg, ba_next;
    rec_t best_rec_reg, best_rec_next;
    logic pend_v_reg, pend_v_next;
    logic [3:0] pend_slot_reg, pend_slot_next;
    logic [15:0] pend_tag_reg, pend_tag_next;
    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;

    logic out_free;
    logic [TIME_BITS-1:0] diff;
    logic [15:0] age;
    logic [15:0] rem_dec;
    logic del_hit;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign in_ready  = (state_reg == S_IDLE) && out_free;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data <= mem[idx_reg];
    end

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        time_next      = time_reg;
        counter_next   = counter_reg;
        valid_next     = valid_reg;
        due_next       = due_reg;
        sel_next       = sel_reg;
        chk_v_next     = chk_v_reg;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bd_next        = bd_reg;
        ba_next        = ba_reg;
        best_rec_next  = best_rec_reg;
        pend_v_next    = pend_v_reg;
        pend_slot_next = pend_slot_reg;
        pend_tag_next  = pend_tag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg;
        mem_wd         = rd_data;
        diff           = time_reg - rd_data.expiry;
        age            = counter_reg - rd_data.order;
        rem_dec        = best_rec_reg.remaining - 16'd1;
        del_hit        = (32'(in_item.timer_id) < SLOTS) && valid_reg[SW'(in_item.timer_id)];

        // Evaluate the slot whose read was registered in the cycle before
        if (chk_v_reg) begin
            if (!sel_reg) begin
                due_next[chk_idx_reg] = valid_reg[chk_idx_reg] && !diff[TIME_BITS-1];
            end else if (due_reg[chk_idx_reg] &&
                         (!found_reg || diff > bd_reg ||
                          (diff == bd_reg && age > ba_reg))) begin
                found_next    = 1'b1;
                best_next     = chk_idx_reg;
                bd_next       = diff;
                ba_next       = age;
                best_rec_next = rd_data;
            end
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && out_free) begin
                    item_next = in_item;
                    unique case (in_item.cmd)
                        CMD_ADD: begin
                            idx_next   = '0;
                            state_next = S_ADD;
                        end
                        CMD_DEL: begin
                            if (del_hit) begin
                                valid_next[SW'(in_item.timer_id)] = 1'b0;
                            end
                            out_valid_next   = 1'b1;
                            out_next.kind    = KIND_DEL;
                            out_next.slot_id = in_item.timer_id;
                            out_next.tag     = 16'd0;
                            out_next.status  = del_hit ? ST_OK : ST_NOT_FOUND;
                            out_next.last    = 1'b1;
                        end
                        CMD_TICK: begin
                            time_next   = time_reg + TIME_BITS'(1);
                            idx_next    = '0;
                            sel_next    = 1'b0;
                            pend_v_next = 1'b0;
                            state_next  = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                out_next.kind = KIND_ADD;
                out_next.tag  = 16'd0;
                out_next.last = 1'b1;
                if (!valid_reg[idx_reg]) begin
                    mem_we            = 1'b1;
                    mem_wa            = idx_reg;
                    mem_wd.expiry     = time_reg + TIME_BITS'(item_reg.delay);
                    mem_wd.period     = item_reg.period;
                    mem_wd.remaining  = item_reg.repeat_count;
                    mem_wd.tag        = item_reg.event_tag;
                    mem_wd.order      = counter_reg;
                    counter_next      = counter_reg + 16'd1;
                    valid_next[idx_reg] = 1'b1;
                    out_valid_next    = 1'b1;
                    out_next.slot_id  = 4'(idx_reg);
                    out_next.status   = ST_OK;
                    state_next        = S_IDLE;
                end else if (idx_reg == LAST_IDX) begin
                    out_valid_next   = 1'b1;
                    out_next.slot_id = 4'd0;
                    out_next.status  = ST_FULL;
                    state_next       = S_IDLE;
                end else begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            S_SCAN: begin
                chk_v_next   = 1'b1;
                chk_idx_next = idx_reg;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_WAIT;
                end else begin
                    idx_next = idx_reg + SW'(1);
                end
            end
            S_WAIT: begin
                chk_v_next = 1'b0;
                if (!sel_reg) begin
                    sel_next   = 1'b1;
                    found_next = 1'b0;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!pend_v_reg || out_free) begin
                    // Release the previous firing once its successor is known
                    if (pend_v_reg) begin
                        out_valid_next   = 1'b1;
                        out_next.kind    = KIND_FIRE;
                        out_next.slot_id = pend_slot_reg;
                        out_next.tag     = pend_tag_reg;
                        out_next.status  = ST_OK;
                        out_next.last    = !found_reg;
                    end
                    if (found_reg) begin
                        due_next[best_reg] = 1'b0;
                        pend_v_next    = 1'b1;
                        pend_slot_next = 4'(best_reg);
                        pend_tag_next  = best_rec_reg.tag;
                        mem_wa         = best_reg;
                        mem_wd         = best_rec_reg;
                        if (best_rec_reg.remaining != 16'd0 && rem_dec == 16'd0) begin
                            valid_next[best_reg] = 1'b0;
                        end else begin
                            // Re-arm one period after now
                            mem_we           = 1'b1;
                            mem_wd.remaining = (best_rec_reg.remaining != 16'd0) ?
                                               rem_dec : 16'd0;
                            mem_wd.expiry    = time_reg + TIME_BITS'(best_rec_reg.period);
                            mem_wd.order     = counter_reg;
                            counter_next     = counter_reg + 16'd1;
                        end
                        found_next = 1'b0;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end else begin
                        pend_v_next = 1'b0;
                        state_next  = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            counter_reg   <= 16'd0;
            valid_reg     <= '0;
            due_reg       <= '0;
            sel_reg       <= 1'b0;
            chk_v_reg     <= 1'b0;
            found_reg     <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            counter_reg   <= counter_next;
            valid_reg     <= valid_next;
            due_reg       <= due_next;
            sel_reg       <= sel_next;
            chk_v_reg     <= chk_v_next;
            found_reg     <= found_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        chk_idx_reg   <= chk_idx_next;
        best_reg      <= best_next;
        bd_reg        <= bd_next;
        ba_reg        <= ba_next;
        best_rec_reg  <= best_rec_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        out_reg       <= out_next;
    end

endmodule
`default_nettype wire

### design/sorted_repeating_timer_queue.sv
// Top level of the sorted repeating timer queue.
// A table of SLOTS timers driven by add, delete and tick commands. Add takes the
// lowest free slot, found by a scan over the slots; delete needs no scan. A tick
// makes one pass over the table to mark due timers and another to find the
// first, then one more pass for each further firing, since every pick of the
// earliest due timer is a full pass over the table memory's single read port.
// A two-entry queue lets new commands arrive while the engine works, and results
// leave through an output register. Firings come earliest expiry first, ties in
// oldest arming first; the last result of any command with results has tlast set.
`timescale 1ns / 1ps
`default_nettype none
module sorted_repeating_timer_queue #(
    parameter int SLOTS     = srtq_pkg::SLOTS_DEF,
    parameter int TIME_BITS = srtq_pkg::TIME_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // timer_id[3:0], period[35:4], first_delay[67:36], repeat_count[83:68],
    // event_tag[99:84], zero fill
    input  wire logic [103:0] s_tdata,
    // command[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // slot_id[3:0], tag[19:4], status[21:20], zero fill
    output logic [23:0]       m_tdata,
    // kind[1:0]
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import srtq_pkg::*;

    logic  f_valid, f_ready;
    item_t f_item;
    logic  q_valid, q_ready;
    item_t q_item;
    res_t  res;

    srtq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    srtq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    srtq_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.status, res.tag, res.slot_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the sorted repeating timer queue.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import srtq_pkg::*;

    localparam int NSLOT = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  timer_id;
        logic [31:0] period;
        logic [31:0] first_delay;
        logic [15:0] repeat_count;
        logic [15:0] event_tag;
    } cmd_item_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    sorted_repeating_timer_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Shadow timer table
    logic [31:0] now_ticks;
    logic        live [NSLOT];
    logic [31:0] due_at [NSLOT];
    logic [31:0] per_ticks [NSLOT];
    logic [15:0] fires_left [NSLOT];
    logic [15:0] ev_tag [NSLOT];
    logic [15:0] arm_seq [NSLOT];
    logic [15:0] seq_ctr;

    cmd_item_t pending_cmds[$];
    res_t      expected_results[$];
    int        error_count = 0;
    int        live_count = 0;
    bit        stim_done = 1'b0;
    bit        hold_done = 1'b0;
    bit        in_acc = 1'b0;
    bit        out_acc = 1'b0;
    int        hold_cycles = 0;
    int        idle_cycles = 0;
    int        src_gap = 0;
    int        sink_gap = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void push_result(kind_t k, logic [3:0] s, logic [15:0] t,
                                        status_t st, logic l);
        res_t r;
        r.kind = k; r.slot_id = s; r.tag = t; r.status = st; r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void arm_slot(int s, logic [31:0] dly);
        due_at[s] = now_ticks + dly;
        arm_seq[s] = seq_ctr;
        seq_ctr = seq_ctr + 16'd1;
    endfunction

    // Compute the results of one accepted command and update the shadow table
    function automatic void predict_timer_events(cmd_item_t c);
        logic [31:0] per;
        logic        due [NSLOT];
        int          s, best, n, free_s;
        logic [31:0] d, bd;
        logic [15:0] a, ba;
        res_t        lr;
        case (c.cmd)
            CMD_ADD: begin
                per = (c.period == 0) ? 32'd1 : c.period;
                free_s = -1;
                for (s = NSLOT - 1; s >= 0; s--)
                    if (!live[s]) free_s = s;
                if (free_s < 0) begin
                    push_result(KIND_ADD, 4'd0, 16'd0, ST_FULL, 1'b1);
                end else begin
                    live[free_s] = 1'b1;
                    per_ticks[free_s] = per;
                    fires_left[free_s] = c.repeat_count;
                    ev_tag[free_s] = c.event_tag;
                    arm_slot(free_s, (c.first_delay != 0) ? c.first_delay : per);
                    push_result(KIND_ADD, free_s[3:0], 16'd0, ST_OK, 1'b1);
                end
            end
            CMD_DEL: begin
                if (live[c.timer_id]) begin
                    live[c.timer_id] = 1'b0;
                    push_result(KIND_DEL, c.timer_id, 16'd0, ST_OK, 1'b1);
                end else begin
                    push_result(KIND_DEL, c.timer_id, 16'd0, ST_NOT_FOUND, 1'b1);
                end
            end
            CMD_TICK: begin
                now_ticks = now_ticks + 32'd1;
                for (s = 0; s < NSLOT; s++)
                    due[s] = live[s] && ((now_ticks - due_at[s]) < 32'h8000_0000);
                n = 0;
                forever begin
                    best = -1; bd = 0; ba = 0;
                    for (s = 0; s < NSLOT; s++) begin
                        if (due[s]) begin
                            d = now_ticks - due_at[s];
                            a = seq_ctr - arm_seq[s];
                            if (best < 0 || d > bd || (d == bd && a > ba)) begin
                                best = s; bd = d; ba = a;
                            end
                        end
                    end
                    if (best < 0) break;
                    due[best] = 1'b0;
                    push_result(KIND_FIRE, best[3:0], ev_tag[best], ST_OK, 1'b0);
                    n++;
                    if (fires_left[best] != 0) begin
                        fires_left[best] = fires_left[best] - 16'd1;
                        if (fires_left[best] == 0) begin
                            live[best] = 1'b0;
                            continue;
                        end
                    end
                    arm_slot(best, per_ticks[best]);
                end
                if (n > 0) begin
                    lr = expected_results.pop_back();
                    lr.last = 1'b1;
                    expected_results.push_back(lr);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic cmd_item_t make_cmd(cmd_t op, logic [3:0] id, logic [31:0] per,
                                           logic [31:0] dly, logic [15:0] cnt,
                                           logic [15:0] tg);
        cmd_item_t c;
        c.cmd = op; c.timer_id = id; c.period = per; c.first_delay = dly;
        c.repeat_count = cnt; c.event_tag = tg;
        return c;
    endfunction

    function automatic cmd_item_t random_add();
        logic [31:0] per, dly;
        int sel;
        sel = $urandom_range(0, 19);
        per = (sel == 0) ? $urandom : (sel == 1) ? 32'd0 : $urandom_range(1, 6);
        sel = $urandom_range(0, 19);
        dly = (sel == 0) ? $urandom : (sel < 5) ? 32'd0 : $urandom_range(1, 8);
        return make_cmd(CMD_ADD, 4'($urandom), per, dly, 16'($urandom_range(0, 4)),
                        16'($urandom));
    endfunction

    // Stimulus
    initial begin
        int i, r;
        for (i = 0; i < NSLOT; i++) begin
            live[i] = 1'b0; due_at[i] = '0; per_ticks[i] = '0;
            fires_left[i] = '0; ev_tag[i] = '0; arm_seq[i] = '0;
        end
        now_ticks = '0;
        seq_ctr = '0;
        // directed: delete on empty, extremes, full table, unused code, wrap
        pending_cmds.push_back(make_cmd(CMD_DEL, 4'd15, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_TICK, 4'hF, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(CMD_NOP, 4'hF, '1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(CMD_ADD, 4'hF, 32'd0, 32'd0, 16'd2, 16'hFFFF));
        pending_cmds.push_back(make_cmd(CMD_ADD, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        16'hFFFF, 16'h0000));
        pending_cmds.push_back(make_cmd(CMD_ADD, 4'h5, 32'd1, 32'h8000_0000, 16'd1,
                                        16'hA5A5));
        pending_cmds.push_back(make_cmd(CMD_ADD, 4'h0, 32'd3, 32'd1, 16'd0, 16'h5A5A));
        pending_cmds.push_back(make_cmd(CMD_ADD, 4'h0, 32'd2, 32'd1, 16'd3, 16'h1234));
        for (i = 0; i < 11; i++)
            pending_cmds.push_back(make_cmd(CMD_ADD, i[3:0], 32'd2, 32'd2, 16'd1, i[15:0]));
        pending_cmds.push_back(make_cmd(CMD_ADD, 4'h0, '1, '1, '1, '1));
        for (i = 0; i < 3; i++)
            pending_cmds.push_back(make_cmd(CMD_TICK, 4'h0, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_DEL, 4'd1, '0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(CMD_DEL, 4'd1, '0, '0, '0, '0));
        // random: mostly adds and ticks so timers fire, some deletes and noise
        for (i = 0; i < 145; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                pending_cmds.push_back(random_add());
            else if (r < 50)
                pending_cmds.push_back(make_cmd(CMD_DEL, 4'($urandom), $urandom, $urandom,
                                                16'($urandom), 16'($urandom)));
            else if (r < 97)
                pending_cmds.push_back(make_cmd(CMD_TICK, 4'($urandom), $urandom, $urandom,
                                                16'($urandom), 16'($urandom)));
            else
                pending_cmds.push_back(make_cmd(CMD_NOP, 4'($urandom), $urandom, $urandom,
                                                16'($urandom), 16'($urandom)));
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: offers items at the falling edge after a random gap
    always @(negedge aclk) begin : drv
        int gap;
        cmd_item_t c;
        if (aresetn) begin
            // in_acc tells whether the offered transaction went in at the last rising edge
            if (!s_tvalid || in_acc) begin
                gap = s_tvalid ? int'($urandom_range(0, 7)) : src_gap;
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    src_gap  <= gap - 1;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    s_tuser  <= c.cmd;
                    s_tdata  <= {4'd0, c.event_tag, c.repeat_count, c.first_delay,
                                 c.period, c.timer_id};
                    s_tvalid <= 1'b1;
                    src_gap  <= 0;
                end else begin
                    s_tvalid  <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // Receiver readiness with random stalls and one long hold-off
    always @(negedge aclk) begin : rcv
        int gap;
        if (aresetn) begin
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && live_count >= 40) begin
                hold_cycles <= 600;
                hold_done <= 1'b1;
                m_tready <= 1'b0;
            end else if (out_acc) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 7));
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    sink_gap <= gap - 1;
                    m_tready <= 1'b0;
                end
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance
    always @(posedge aclk) begin
        if (aresetn) begin
            in_acc  <= s_tvalid && s_tready;
            out_acc <= m_tvalid && m_tready;
            if (s_tvalid && s_tready) begin
                predict_timer_events(make_cmd(cmd_t'(s_tuser), s_tdata[3:0], s_tdata[35:4],
                                              s_tdata[67:36], s_tdata[83:68],
                                              s_tdata[99:84]));
                live_count <= live_count + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result slot", m_tdata[3:0], -1);
                end else begin
                    res_t e;
                    e = expected_results.pop_front();
                    if (m_tuser != e.kind) report_mismatch("kind", m_tuser, e.kind);
                    if (m_tdata[3:0] != e.slot_id)
                        report_mismatch("slot_id", m_tdata[3:0], e.slot_id);
                    if (m_tdata[19:4] != e.tag) report_mismatch("tag", m_tdata[19:4], e.tag);
                    if (m_tdata[21:20] != e.status)
                        report_mismatch("status", m_tdata[21:20], e.status);
                    if (m_tlast != e.last) report_mismatch("last", m_tlast, e.last);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // End of run and watchdog
    initial begin
        wait (aresetn);
        wait ((stim_done && expected_results.size() == 0) || idle_cycles >= WATCHDOG_LIMIT);
        if (idle_cycles < WATCHDOG_LIMIT) begin
            repeat (200) @(posedge aclk);
            if (error_count == 0 && expected_results.size() == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
design/srtq_pkg.sv
design/srtq_front.sv
design/srtq_queue.sv
design/srtq_back.sv
design/sorted_repeating_timer_queue.sv
verif/testbench.sv
